// ===== rtl/mfbr_pkg.sv =====
// Shared types and codes for the MSB-first bit reader.
`default_nettype none
package mfbr_pkg;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_ALIGN = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int WORD_W   = 32;
    localparam int CNT_W    = 6;
    localparam int AVAIL_W  = 10;
    localparam int AVAIL_MAX = 1023;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_ALIGN = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             op;
        logic [WORD_W-1:0]   word;
        logic [CNT_W-1:0]    cnt;   // clamped to 0..32
    } t_op;

endpackage
`default_nettype wire

// ===== rtl/mfbr_front.sv =====
// Front part: decodes requests and holds them in a two-entry queue.
`default_nettype none
module mfbr_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_func,
    input  wire logic [mfbr_pkg::WORD_W-1:0] i_word_in,
    input  wire logic [mfbr_pkg::CNT_W-1:0]  i_bit_count,
    output logic                             o_q_valid,
    output mfbr_pkg::t_op                    o_q_op,
    input  wire logic                        i_q_pop
);
    import mfbr_pkg::*;

    t_op        r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_qcnt;
    logic [1:0] n_qcnt;
    t_op        n_entry;
    logic       push;

    always_comb begin
        n_entry.word = i_word_in;
        n_entry.cnt  = (i_bit_count > CNT_W'(32)) ? CNT_W'(32) : i_bit_count;
        unique case (i_func)
            FUNC_PUSH:  n_entry.op = OP_PUSH;
            FUNC_READ:  n_entry.op = OP_READ;
            FUNC_ALIGN: n_entry.op = OP_ALIGN;
            default:    n_entry.op = OP_NONE;
        endcase
    end

    assign o_ready   = (r_qcnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_qcnt != 2'd0);
    assign o_q_op    = r_q[r_rd];

    always_comb begin
        n_qcnt = r_qcnt;
        if (push && !i_q_pop) begin
            n_qcnt = r_qcnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_qcnt = r_qcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            r_qcnt <= n_qcnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mfbr_back.sv =====
// Back part: word ring, two-word head window, bit extraction and result register.
`default_nettype none
module mfbr_back #(
    parameter int BUF_WORDS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire mfbr_pkg::t_op                 i_q_op,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [mfbr_pkg::WORD_W-1:0]        o_value,
    output logic [1:0]                         o_status,
    output logic [mfbr_pkg::AVAIL_W-1:0]       o_bits_available
);
    import mfbr_pkg::*;

    localparam int PW  = $clog2(BUF_WORDS);
    localparam int CW  = $clog2(BUF_WORDS + 1);
    localparam int AW  = CW + 5;
    localparam int AVW = (AW > 11) ? AW : 11;

    // ring of words not yet moved into the window
    logic [WORD_W-1:0] r_mem [BUF_WORDS];
    logic [WORD_W-1:0] r_mdata;
    logic [PW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_mcnt, n_mcnt;
    logic              r_fetch_v;

    // architectural position
    logic [CW-1:0]     r_count, n_count;
    logic [4:0]        r_offset, n_offset;

    // head window: word at head and the one after it
    logic [WORD_W-1:0] r_win0, r_win1, n_win0, n_win1;
    logic [1:0]        r_wv, n_wv, wv_after;

    logic                r_ovalid;
    logic [WORD_W-1:0]   r_value;
    logic [1:0]          r_status;
    logic [AVAIL_W-1:0]  r_avail;

    logic [AW-1:0]       avail;
    logic [AVW-1:0]      nav;
    logic                is_read, is_align, is_push;
    logic                underflow, need2, stall, go, do_adv, freed_w, push_ok, fetch;
    logic [5:0]          left, newpos;
    logic [2*WORD_W-1:0] shifted;
    logic [WORD_W-1:0]   top, value;
    logic [1:0]          status;

    always_comb begin
        is_read  = (i_q_op.op == OP_READ);
        is_align = (i_q_op.op == OP_ALIGN);
        is_push  = (i_q_op.op == OP_PUSH);

        avail     = {r_count, 5'b0} - AW'(r_offset);
        underflow = AW'(i_q_op.cnt) > avail;
        left      = 6'd32 - {1'b0, r_offset};
        need2     = i_q_op.cnt > left;

        // a read may need words still on their way from the ring
        stall = is_read && !underflow && (i_q_op.cnt != '0)
                && (need2 ? (r_wv != 2'd2) : (r_wv == 2'd0));
        go    = i_q_valid && !stall && (!r_ovalid || i_ready);

        if (is_read) begin
            newpos = {1'b0, r_offset} + i_q_op.cnt;
        end else begin
            newpos = ({1'b0, r_offset} + 6'd7) & ~6'd7;
        end

        do_adv  = go && ((is_read && !underflow && (i_q_op.cnt != '0))
                         || (is_align && (r_count != '0)));
        freed_w = do_adv && newpos[5];
        push_ok = go && is_push && (r_count < CW'(BUF_WORDS));

        n_count  = r_count;
        n_offset = r_offset;
        if (push_ok) begin
            n_count = r_count + CW'(1);
        end else if (do_adv) begin
            n_count  = r_count - CW'(freed_w);
            n_offset = (n_count == '0) ? 5'd0 : newpos[4:0];
        end

        shifted = {r_win0, r_win1} << r_offset;
        top     = shifted[2*WORD_W-1:WORD_W];
        value   = '0;
        status  = ST_OK;
        if (is_read && underflow) begin
            status = ST_UNDER;
        end else if (is_read && (i_q_op.cnt != '0)) begin
            value = top >> (6'd32 - i_q_op.cnt);
        end else if (is_push && !push_ok) begin
            status = ST_FULL;
        end

        nav = AVW'({n_count, 5'b0}) - AVW'(n_offset);
    end

    // window refill from the ring
    always_comb begin
        fetch    = (r_mcnt != '0) && ((3'(r_wv) + 3'(r_fetch_v)) < 3'd2);
        n_mcnt   = r_mcnt + CW'(push_ok) - CW'(fetch);
        wv_after = r_wv - 2'(freed_w);
        n_wv     = wv_after + 2'(r_fetch_v);
        n_win0   = freed_w ? r_win1 : r_win0;
        n_win1   = r_win1;
        if (r_fetch_v) begin
            if (wv_after == 2'd0) begin
                n_win0 = r_mdata;
            end else begin
                n_win1 = r_mdata;
            end
        end
    end

    assign o_q_pop          = go;
    assign o_valid          = r_ovalid;
    assign o_value          = r_value;
    assign o_status         = r_status;
    assign o_bits_available = r_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_rd      <= '0;
            r_mcnt    <= '0;
            r_fetch_v <= 1'b0;
            r_count   <= '0;
            r_offset  <= '0;
            r_wv      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_mcnt    <= n_mcnt;
            r_fetch_v <= fetch;
            r_count   <= n_count;
            r_offset  <= n_offset;
            r_wv      <= n_wv;
            if (push_ok) begin
                r_wr <= (r_wr == PW'(BUF_WORDS - 1)) ? '0 : r_wr + PW'(1);
            end
            if (fetch) begin
                r_rd <= (r_rd == PW'(BUF_WORDS - 1)) ? '0 : r_rd + PW'(1);
            end
            if (go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win0 <= n_win0;
        r_win1 <= n_win1;
        if (go) begin
            r_value  <= value;
            r_status <= status;
            r_avail  <= (nav > AVW'(AVAIL_MAX)) ? AVAIL_W'(AVAIL_MAX) : nav[AVAIL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_q_op.word;
        end
        if (fetch) begin
            r_mdata <= r_mem[r_rd];
        end
    end

`ifndef SYNTH
    a_word_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == r_mcnt + CW'(r_wv) + CW'(r_fetch_v))
        else $error("stored word count does not match ring plus window");

    a_window_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (3'(r_wv) + 3'(r_fetch_v)) <= 3'd2)
        else $error("head window overfilled");

    a_empty_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_offset == 5'd0))
        else $error("bit offset nonzero with no stored words");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status != ST_OK)) |-> (r_value == '0))
        else $error("failed request returned nonzero value");
`endif

endmodule
`default_nettype wire

// ===== rtl/msb_first_bit_reader_top.sv =====
// An accepted request passes through the request queue and then the result register.
// Throughput: one request per cycle while i_ready is high; a read needing a word not yet in
// the head window waits for the ring read port (recent pushes, or the word after a freed one).
// The two-entry request queue and the result register let each side stall on its own.
// Reset: synchronous, active low; clears the queue, position and word counts.
// Ring contents are not cleared; only written words are ever read.
`default_nettype none
module msb_first_bit_reader_top #(
    parameter int BUF_WORDS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [mfbr_pkg::WORD_W-1:0]    i_word_in,
    input  wire logic [mfbr_pkg::CNT_W-1:0]     i_bit_count,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [mfbr_pkg::WORD_W-1:0]         o_value,
    output logic [1:0]                          o_status,
    output logic [mfbr_pkg::AVAIL_W-1:0]        o_bits_available
);
    import mfbr_pkg::*;

    logic q_valid, q_pop;
    t_op  q_op;

    mfbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_word_in   (i_word_in),
        .i_bit_count (i_bit_count),
        .o_q_valid   (q_valid),
        .o_q_op      (q_op),
        .i_q_pop     (q_pop)
    );

    mfbr_back #(
        .BUF_WORDS (BUF_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_op           (q_op),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_value          (o_value),
        .o_status         (o_status),
        .o_bits_available (o_bits_available)
    );

endmodule
`default_nettype wire
